@@ sv/oltbl_pkg.sv @@
`timescale 1ns / 1ps

package oltbl_pkg;

  localparam int unsigned WordW = 32;

  // Command codes
  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_PUSH   = 3'd1;
  localparam logic [2:0] CMD_POP    = 3'd2;
  localparam logic [2:0] CMD_REMOVE = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;
  localparam logic [2:0] CMD_LENGTH = 3'd5;

  // Status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_EMPTY    = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]              cmd;
    logic signed [WordW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [WordW-1:0] data_out;
    logic [4:0]              length;
  } out_t;

  // Comparison selected on the shared compare unit
  typedef enum logic [1:0] {
    MATCH_ALWAYS,
    MATCH_GT,
    MATCH_GE,
    MATCH_EQ
  } match_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS,
    ST_TAIL,
    ST_DEL,
    ST_RV_A,
    ST_RV_B,
    ST_RV_C,
    ST_RV_D,
    ST_FIN
  } state_e;

endpackage

@@ sv/oltbl_ram.sv @@
`timescale 1ns / 1ps

module oltbl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ sv/oltbl_cmp.sv @@
`timescale 1ns / 1ps

module oltbl_cmp (
  input  logic signed [oltbl_pkg::WordW-1:0] entry_i,
  input  logic signed [oltbl_pkg::WordW-1:0] value_i,
  input  oltbl_pkg::match_e                  mode_i,
  output logic                               hit_o
);

  always_comb begin
    unique case (mode_i)
      oltbl_pkg::MATCH_ALWAYS: hit_o = 1'b1;
      oltbl_pkg::MATCH_GT:     hit_o = entry_i > value_i;
      oltbl_pkg::MATCH_GE:     hit_o = entry_i >= value_i;
      oltbl_pkg::MATCH_EQ:     hit_o = entry_i == value_i;
      default:                 hit_o = 1'b0;
    endcase
  end

endmodule

@@ sv/ordered_list_table.sv @@
`timescale 1ns / 1ps

// Channel  Direction  Payload              Handshake
// in       input      oltbl_pkg::in_t      in_valid_i / in_stall_o
// out      output     oltbl_pkg::out_t     out_valid_o / out_stall_i
//
// Insert, push, pop and remove walk the list once through the single RAM read
// port and the shared compare unit. Reverse swaps one pair at a time from both
// ends inward: read the low entry, read the high one, write each to the other's
// slot. Length, unused codes, a full insert or push and an empty pop go straight
// to the result. Reset empties the list through the count alone; RAM content is
// not cleared. A result waits in the output register under out_stall_i; the next
// transaction is taken meanwhile and its result is held until the register frees.

module ordered_list_table #(
  parameter int unsigned DEPTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  oltbl_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output oltbl_pkg::out_t  out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

  oltbl_pkg::state_e state_q, state_d;

  logic [2:0]                        op_q, op_d;
  logic signed [oltbl_pkg::WordW-1:0] val_q, val_d;
  logic [CW-1:0]                     count_q, count_d;
  logic [CW-1:0]                     rd_q, rd_d;
  logic                              pend_q, pend_d;
  logic [AW-1:0]                     pidx_q, pidx_d;
  logic                              found_q, found_d;
  logic [oltbl_pkg::WordW-1:0]       carry_q, carry_d;
  logic [AW-1:0]                     lo_q, lo_d;
  logic [AW-1:0]                     hi_q, hi_d;
  logic [oltbl_pkg::WordW-1:0]       tmp_q, tmp_d;
  logic [1:0]                        status_q, status_d;
  logic [oltbl_pkg::WordW-1:0]       data_q, data_d;
  logic                              out_valid_q, out_valid_d;
  oltbl_pkg::out_t                   out_q, out_d;

  logic                         wr_en, rd_en;
  logic [AW-1:0]                wr_addr, rd_addr;
  logic [oltbl_pkg::WordW-1:0]  wr_data, rd_data;
  oltbl_pkg::match_e            mode;
  logic                         hit;

  logic          accept, is_full, is_empty, scan_done, out_free;
  logic [CW-1:0] cnt_m1;
  logic [AW-1:0] lo_inc, hi_dec;

  assign accept    = in_valid_i && !in_stall_o;
  assign is_full   = count_q == FullCnt;
  assign is_empty  = count_q == '0;
  assign scan_done = (rd_q == count_q) && !pend_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign cnt_m1    = count_q - CW'(1);
  assign lo_inc    = lo_q + AW'(1);
  assign hi_dec    = hi_q - AW'(1);

  assign in_stall_o  = state_q != oltbl_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  oltbl_ram #(
    .WIDTH(oltbl_pkg::WordW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  oltbl_cmp u_cmp (
    .entry_i (signed'(rd_data)),
    .value_i (val_q),
    .mode_i  (mode),
    .hit_o   (hit)
  );

  // Comparison for the entry now on the read port
  always_comb begin
    priority if (state_q == oltbl_pkg::ST_INS) begin
      if (op_q == oltbl_pkg::CMD_PUSH) begin
        mode = oltbl_pkg::MATCH_ALWAYS;
      end else if (pidx_q == '0) begin
        mode = oltbl_pkg::MATCH_GT;
      end else begin
        mode = oltbl_pkg::MATCH_GE;
      end
    end else if (op_q == oltbl_pkg::CMD_POP) begin
      mode = oltbl_pkg::MATCH_ALWAYS;
    end else begin
      mode = oltbl_pkg::MATCH_EQ;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oltbl_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.cmd)
            oltbl_pkg::CMD_INSERT,
            oltbl_pkg::CMD_PUSH:    state_d = is_full ? oltbl_pkg::ST_FIN : oltbl_pkg::ST_INS;
            oltbl_pkg::CMD_POP:     state_d = is_empty ? oltbl_pkg::ST_FIN : oltbl_pkg::ST_DEL;
            oltbl_pkg::CMD_REMOVE:  state_d = oltbl_pkg::ST_DEL;
            oltbl_pkg::CMD_REVERSE: begin
              state_d = (count_q > CW'(1)) ? oltbl_pkg::ST_RV_A : oltbl_pkg::ST_FIN;
            end
            default:                state_d = oltbl_pkg::ST_FIN;
          endcase
        end
      end
      oltbl_pkg::ST_INS:  if (scan_done) state_d = oltbl_pkg::ST_TAIL;
      oltbl_pkg::ST_TAIL: state_d = oltbl_pkg::ST_FIN;
      oltbl_pkg::ST_DEL:  if (scan_done) state_d = oltbl_pkg::ST_FIN;
      oltbl_pkg::ST_RV_A: state_d = oltbl_pkg::ST_RV_B;
      oltbl_pkg::ST_RV_B: state_d = oltbl_pkg::ST_RV_C;
      oltbl_pkg::ST_RV_C: state_d = oltbl_pkg::ST_RV_D;
      oltbl_pkg::ST_RV_D: state_d = (lo_inc < hi_dec) ? oltbl_pkg::ST_RV_A : oltbl_pkg::ST_FIN;
      oltbl_pkg::ST_FIN:  if (out_free) state_d = oltbl_pkg::ST_IDLE;
      default:            state_d = oltbl_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    op_d        = op_q;
    val_d       = val_q;
    count_d     = count_q;
    rd_d        = rd_q;
    pend_d      = pend_q;
    pidx_d      = pidx_q;
    found_d     = found_q;
    carry_d     = carry_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    tmp_d       = tmp_q;
    status_d    = status_q;
    data_d      = data_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    wr_en       = 1'b0;
    wr_addr     = pidx_q;
    wr_data     = carry_q;
    rd_en       = 1'b0;
    rd_addr     = rd_q[AW-1:0];

    unique case (state_q)
      oltbl_pkg::ST_IDLE: begin
        if (accept) begin
          op_d     = in_data_i.cmd;
          val_d    = in_data_i.value;
          rd_d     = '0;
          pend_d   = 1'b0;
          found_d  = 1'b0;
          carry_d  = in_data_i.value;
          lo_d     = '0;
          hi_d     = cnt_m1[AW-1:0];
          status_d = oltbl_pkg::STATUS_OK;
          data_d   = '0;
          if ((in_data_i.cmd == oltbl_pkg::CMD_INSERT || in_data_i.cmd == oltbl_pkg::CMD_PUSH)
              && is_full) begin
            status_d = oltbl_pkg::STATUS_FULL;
          end
          if (in_data_i.cmd == oltbl_pkg::CMD_POP && is_empty) begin
            status_d = oltbl_pkg::STATUS_EMPTY;
          end
        end
      end
      oltbl_pkg::ST_INS, oltbl_pkg::ST_DEL: begin
        // Issue the next read while the previous entry is processed
        if (rd_q != count_q) begin
          rd_en  = 1'b1;
          rd_d   = rd_q + CW'(1);
          pend_d = 1'b1;
          pidx_d = rd_q[AW-1:0];
        end else begin
          pend_d = 1'b0;
        end
        if (state_q == oltbl_pkg::ST_INS) begin
          // Ripple the carried word down the list from the insert point
          if (pend_q && (found_q || hit)) begin
            wr_en   = 1'b1;
            wr_addr = pidx_q;
            wr_data = carry_q;
            carry_d = rd_data;
            found_d = 1'b1;
          end
        end else begin
          if (pend_q) begin
            if (found_q) begin
              // Close the gap: move each later entry up one slot
              wr_en   = 1'b1;
              wr_addr = pidx_q - AW'(1);
              wr_data = rd_data;
            end else if (hit) begin
              found_d = 1'b1;
              if (op_q == oltbl_pkg::CMD_POP) begin
                data_d = rd_data;
              end
            end
          end
          if (scan_done) begin
            if (found_q) begin
              count_d = cnt_m1;
            end else begin
              status_d = oltbl_pkg::STATUS_NOTFOUND;
            end
          end
        end
      end
      oltbl_pkg::ST_TAIL: begin
        wr_en   = 1'b1;
        wr_addr = count_q[AW-1:0];
        wr_data = carry_q;
        count_d = count_q + CW'(1);
      end
      oltbl_pkg::ST_RV_A: begin
        rd_en   = 1'b1;
        rd_addr = lo_q;
      end
      oltbl_pkg::ST_RV_B: begin
        rd_en   = 1'b1;
        rd_addr = hi_q;
        tmp_d   = rd_data;
      end
      oltbl_pkg::ST_RV_C: begin
        wr_en   = 1'b1;
        wr_addr = lo_q;
        wr_data = rd_data;
      end
      oltbl_pkg::ST_RV_D: begin
        wr_en   = 1'b1;
        wr_addr = hi_q;
        wr_data = tmp_q;
        lo_d    = lo_inc;
        hi_d    = hi_dec;
      end
      oltbl_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.status    = status_q;
          out_d.data_out  = signed'(data_q);
          out_d.length    = 5'(count_q);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= oltbl_pkg::ST_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    pidx_q   <= pidx_d;
    carry_q  <= carry_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    tmp_q    <= tmp_d;
    status_q <= status_d;
    data_q   <= data_d;
    out_q    <= out_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCnt)
    else $error("entry count above depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (CW'(wr_addr) <= count_q))
    else $error("RAM write beyond the tail");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != oltbl_pkg::ST_IDLE)
    else $error("accepted transaction not started");

  a_count_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |->
      ($past(state_q) == oltbl_pkg::ST_TAIL || $past(state_q) == oltbl_pkg::ST_DEL))
    else $error("entry count changed outside insert or delete");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 1000;
  localparam int unsigned QUIET_FROM   = 850;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES = 60;

  // Codes left unused by the block: no operation
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;

  localparam logic signed [oltbl_pkg::WordW-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [oltbl_pkg::WordW-1:0] WORD_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic [2:0]                  cmd;
    logic [oltbl_pkg::WordW-1:0] value;
    logic [4:0]                  reps;
    logic                        typed;
    oltbl_pkg::out_t             res;
  } script_row_t;

  localparam int unsigned SCRIPT_LEN = 23;

  // Rows with typed set carry the result expected from a fresh list
  script_row_t script [SCRIPT_LEN] = '{
    '{oltbl_pkg::CMD_POP,     32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_EMPTY,    32'h0, 5'd0}},
    '{oltbl_pkg::CMD_REMOVE,  32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_NOTFOUND, 32'h0, 5'd0}},
    '{oltbl_pkg::CMD_LENGTH,  32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd0}},
    '{oltbl_pkg::CMD_REVERSE, 32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd0}},
    '{CMD_SPARE6,             32'hffff_ffff, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd0}},
    '{CMD_SPARE7,             32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd0}},
    '{oltbl_pkg::CMD_INSERT,  32'h7fff_ffff, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd1}},
    '{oltbl_pkg::CMD_INSERT,  32'h8000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd2}},
    '{oltbl_pkg::CMD_INSERT,  32'h8000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd3}},
    '{oltbl_pkg::CMD_INSERT,  32'h0000_0000, 5'd1,  1'b0, '0},
    '{oltbl_pkg::CMD_REMOVE,  32'h0000_0005, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_NOTFOUND, 32'h0, 5'd4}},
    '{oltbl_pkg::CMD_REVERSE, 32'h0000_0000, 5'd1,  1'b0, '0},
    '{oltbl_pkg::CMD_POP,     32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK, 32'h7fff_ffff, 5'd3}},
    '{oltbl_pkg::CMD_PUSH,    32'h1234_5678, 5'd1,  1'b0, '0},
    '{oltbl_pkg::CMD_REMOVE,  32'h8000_0000, 5'd1,  1'b0, '0},
    '{oltbl_pkg::CMD_INSERT,  32'h0000_0000, 5'd1,  1'b0, '0},
    '{oltbl_pkg::CMD_PUSH,    32'haaaa_aaaa, 5'd12, 1'b0, '0},
    '{oltbl_pkg::CMD_INSERT,  32'h0000_0001, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_FULL,     32'h0, 5'd16}},
    '{oltbl_pkg::CMD_PUSH,    32'h5555_5555, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_FULL,     32'h0, 5'd16}},
    '{oltbl_pkg::CMD_LENGTH,  32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_OK,       32'h0, 5'd16}},
    '{oltbl_pkg::CMD_REVERSE, 32'h0000_0000, 5'd1,  1'b0, '0},
    '{oltbl_pkg::CMD_POP,     32'h0000_0000, 5'd16, 1'b0, '0},
    '{oltbl_pkg::CMD_POP,     32'h0000_0000, 5'd1,  1'b1,
      '{oltbl_pkg::STATUS_EMPTY,    32'h0, 5'd0}}
  };

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            in_valid_i  = 1'b0;
  oltbl_pkg::in_t  in_data_i   = '0;
  logic            out_stall_i = 1'b0;
  logic            in_stall_o;
  logic            out_valid_o;
  oltbl_pkg::out_t out_data_o;

  logic signed [oltbl_pkg::WordW-1:0] shadow_list [DEPTH];
  int unsigned                        shadow_len = 0;
  oltbl_pkg::out_t                    pending_results [$];

  int          errors      = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          quiet       = 1'b0;
  bit          calm        = 1'b0;

  ordered_list_table #(.DEPTH(DEPTH)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void open_slot(int unsigned pos,
                                    logic signed [oltbl_pkg::WordW-1:0] word);
    for (int unsigned i = shadow_len; i > pos; i--) shadow_list[i] = shadow_list[i-1];
    shadow_list[pos] = word;
    shadow_len++;
  endfunction

  function automatic void close_slot(int unsigned pos);
    for (int unsigned i = pos; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
    shadow_len--;
  endfunction

  // Update the shadow list and return the result the command should give
  function automatic oltbl_pkg::out_t apply_command(oltbl_pkg::in_t item);
    oltbl_pkg::out_t                    res;
    int unsigned                        pos;
    bit                                 found;
    logic signed [oltbl_pkg::WordW-1:0] tmp;
    res = '0;
    case (item.cmd)
      oltbl_pkg::CMD_INSERT, oltbl_pkg::CMD_PUSH: begin
        if (shadow_len >= DEPTH) begin
          res.status = oltbl_pkg::STATUS_FULL;
        end else if (item.cmd == oltbl_pkg::CMD_PUSH || shadow_len == 0 ||
                     shadow_list[0] > item.value) begin
          open_slot(0, item.value);
        end else begin
          pos = shadow_len;
          for (int unsigned i = 1; i < shadow_len; i++) begin
            if (shadow_list[i] >= item.value) begin
              pos = i;
              break;
            end
          end
          open_slot(pos, item.value);
        end
      end
      oltbl_pkg::CMD_POP: begin
        if (shadow_len == 0) begin
          res.status = oltbl_pkg::STATUS_EMPTY;
        end else begin
          res.data_out = shadow_list[0];
          close_slot(0);
        end
      end
      oltbl_pkg::CMD_REMOVE: begin
        found = 1'b0;
        for (int unsigned i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == item.value) begin
            close_slot(i);
            found = 1'b1;
            break;
          end
        end
        if (!found) res.status = oltbl_pkg::STATUS_NOTFOUND;
      end
      oltbl_pkg::CMD_REVERSE: begin
        for (int unsigned i = 0; i < shadow_len / 2; i++) begin
          tmp                           = shadow_list[i];
          shadow_list[i]                = shadow_list[shadow_len-1-i];
          shadow_list[shadow_len-1-i]   = tmp;
        end
      end
      default: ;
    endcase
    res.length = shadow_len[4:0];
    return res;
  endfunction

  function automatic logic signed [oltbl_pkg::WordW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: begin
        case ($urandom_range(0, 3))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(0, 15)) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_cmd(oltbl_pkg::in_t item, bit typed, oltbl_pkg::out_t typed_res);
    oltbl_pkg::out_t res;
    res = apply_command(item);
    pending_results.push_back(typed ? typed_res : res);
    if (!quiet && !calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Receiver stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
    end else if (!quiet && !calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 11);
    end
    out_stall_i <= (stall_left != 0) && !quiet;
  end

  always @(posedge clk_i) begin : check_results
    oltbl_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no pending command: status %0d data_out %0h length %0d",
               out_data_o.status, out_data_o.data_out, out_data_o.length);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data_o.status);
          errors++;
        end
        if (out_data_o.data_out !== want.data_out) begin
          $error("data_out: expected %0h, actual %0h", want.data_out, out_data_o.data_out);
          errors++;
        end
        if (out_data_o.length !== want.length) begin
          $error("length: expected %0d, actual %0d", want.length, out_data_o.length);
          errors++;
        end
      end
    end
  end

  // Abort when no transaction moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    oltbl_pkg::in_t item;
    int unsigned    r;
    bit             growing;
    growing = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      for (int unsigned n = 0; n < script[k].reps; n++) begin
        item.cmd   = script[k].cmd;
        item.value = script[k].value;
        send_cmd(item, script[k].typed, script[k].res);
      end
    end

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        calm    = ($urandom_range(0, 3) == 0);
        growing = $urandom_range(0, 1);
      end
      quiet = (n >= QUIET_FROM);
      r = $urandom_range(0, 99);
      // Lean towards filling or draining so both full and empty lists recur
      if (growing) begin
        item.cmd = (r < 35) ? oltbl_pkg::CMD_INSERT :
                   (r < 55) ? oltbl_pkg::CMD_PUSH :
                   (r < 70) ? oltbl_pkg::CMD_POP :
                   (r < 85) ? oltbl_pkg::CMD_REMOVE :
                   (r < 92) ? oltbl_pkg::CMD_REVERSE :
                   (r < 97) ? oltbl_pkg::CMD_LENGTH :
                   (r < 98) ? CMD_SPARE6 : CMD_SPARE7;
      end else begin
        item.cmd = (r < 15) ? oltbl_pkg::CMD_INSERT :
                   (r < 25) ? oltbl_pkg::CMD_PUSH :
                   (r < 55) ? oltbl_pkg::CMD_POP :
                   (r < 85) ? oltbl_pkg::CMD_REMOVE :
                   (r < 92) ? oltbl_pkg::CMD_REVERSE :
                   (r < 97) ? oltbl_pkg::CMD_LENGTH :
                   (r < 98) ? CMD_SPARE6 : CMD_SPARE7;
      end
      item.value = pick_word();
      if (item.cmd == oltbl_pkg::CMD_REMOVE && shadow_len != 0 &&
          $urandom_range(0, 9) < 6) begin
        item.value = shadow_list[$urandom_range(0, shadow_len - 1)];
      end
      send_cmd(item, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/oltbl_pkg.sv
sv/oltbl_ram.sv
sv/oltbl_cmp.sv
sv/ordered_list_table.sv
verif/tb.sv
